// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the fade sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AFS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AFS_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AFS_ASSERT(name, clk, rst_n, prop)
`define AFS_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== src/afs_pkg.sv =====
// Package with types, widths and constants of the appearance fade sequencer.
`timescale 1ns / 1ps
`default_nettype none
package afs_pkg;

    localparam int RATE_W  = 16;
    localparam int DT_W    = 15;
    localparam int HOLD_W  = 20;
    localparam int FADE_W  = 17;
    localparam int STEP_W  = 23;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 52;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [15:0]       ELAPSED_CLAMP = 16'd16384;
    localparam logic [FADE_W-1:0] FADE_ONE      = 17'd65536;
    localparam logic [17:0]       SMOOTH_K3     = 18'd196608;
    localparam logic [31:0]       STEP_ROUND    = 32'd128;
    localparam logic [PROD_W:0]   ALPHA_ROUND   = 53'h0_0000_8000_0000;

    localparam logic [RATE_W-1:0] POP_RATE_RESET   = 16'd3072;
    localparam logic [RATE_W-1:0] LEAVE_RATE_RESET = 16'd1024;
    localparam logic [RATE_W-1:0] EXIT_RATE_RESET  = 16'd2048;

    typedef enum logic [1:0] {
        REG_POP_RATE   = 2'd0,
        REG_LEAVE_RATE = 2'd1,
        REG_EXIT_RATE  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef enum logic {
        ACT_FRAME = 1'b0,
        ACT_HOLD  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_APPLY,
        ST_SQUARE,
        ST_CUBE,
        ST_DONE
    } seq_state_t;

endpackage
`default_nettype wire

// ===== src/appearance_fade_sequencer.sv =====
// Top level of the appearance fade sequencer: control state, sequencer and ports.
//
//   Channel   Direction  Handshake                      Content
//   s_axis    in         s_axis_tvalid / s_axis_tready   frame or exit-hold item
//   m_axis    out        m_axis_tvalid / m_axis_tready   summoned, dismissed, alpha
//   cfg       in         cfg_write_en                   rate registers 0 to 2
//
// A hold item is taken in ST_IDLE, which it does not leave, and gives no transfer on m_axis.
// A frame item passes ST_STEP, ST_APPLY, ST_SQUARE, ST_CUBE and ST_DONE before the
// output register is loaded, skipping ST_STEP and ST_APPLY when the fade stays fixed;
// one shared multiplier forms step, f*f and f*f*k. A finished item waits while the output
// register is full; the next item is let in as soon as the result has been loaded.
// Reset leaves the fade at zero, nothing showing and the rates at their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module appearance_fade_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits from low: wanted, blocker_on_screen, elapsed[15:0], hold_time[19:0], zero pad.
    input  wire logic [afs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Bits from low: action.
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // Bits from low: summoned, dismissed, alpha[16:0], zero pad.
    output logic      [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           cfg_write_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [afs_pkg::RATE_W-1:0]     cfg_data
);

    afs_pkg::seq_state_t state_reg, state_next;

    logic [afs_pkg::RATE_W-1:0] pop_rate_reg, leave_rate_reg, exit_rate_reg;

    logic                       showing_reg, showing_next;
    logic                       awaiting_reg, awaiting_next;
    logic                       had_art_reg, had_art_next;
    logic [afs_pkg::HOLD_W-1:0] hold_left_reg, hold_left_next;
    logic [afs_pkg::FADE_W-1:0] fade_reg, fade_next;

    logic                       move_reg, move_next;
    logic                       up_reg, up_next;
    logic [afs_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [afs_pkg::DT_W-1:0]   dt_reg, dt_next;
    logic                       summ_reg, summ_next;
    logic                       dism_reg, dism_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_summ_reg, out_summ_next;
    logic                       out_dism_reg, out_dism_next;
    logic [afs_pkg::FADE_W-1:0] out_alpha_reg, out_alpha_next;

    logic                        mul_en;
    logic [afs_pkg::MUL_A_W-1:0] mul_a;
    logic [afs_pkg::MUL_B_W-1:0] mul_b;
    logic [afs_pkg::PROD_W-1:0]  prod;

    logic                       in_xfer;
    logic                       in_wanted, in_blocker;
    logic [15:0]                in_elapsed;
    logic [afs_pkg::HOLD_W-1:0] in_hold;
    logic [afs_pkg::DT_W-1:0]   dt_clamped;
    logic                       show, changed, summ, dism;
    logic                       had_art_eff;
    logic [afs_pkg::HOLD_W-1:0] hold_base;
    logic [31:0]                step_sum;
    logic [afs_pkg::STEP_W-1:0] step;
    logic [afs_pkg::FADE_W-1:0] room;
    logic [17:0]                smooth_k;
    logic [afs_pkg::PROD_W:0]   alpha_sum;
    logic [20:0]                alpha_raw;
    logic [afs_pkg::FADE_W-1:0] alpha_val;

    afs_mul_unit u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_wanted  = s_axis_tdata[0];
    assign in_blocker = s_axis_tdata[1];
    assign in_elapsed = s_axis_tdata[17:2];
    assign in_hold    = s_axis_tdata[37:18];

    assign s_axis_tready = (state_reg == afs_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign dt_clamped = (in_elapsed > afs_pkg::ELAPSED_CLAMP) ?
                        afs_pkg::DT_W'(afs_pkg::ELAPSED_CLAMP) : in_elapsed[afs_pkg::DT_W-1:0];
    assign show    = in_wanted && !in_blocker;
    assign changed = (show != showing_reg);
    assign summ    = changed && show;
    assign dism    = changed && !show;
    assign had_art_eff = (!changed && awaiting_reg) ? 1'b0 : had_art_reg;
    assign hold_base   = summ ? '0 : hold_left_reg;

    assign step_sum = {1'b0, prod[30:0]} + afs_pkg::STEP_ROUND;
    assign step     = step_sum[30:8];
    assign room     = afs_pkg::FADE_ONE - fade_reg;
    assign smooth_k = afs_pkg::SMOOTH_K3 - {fade_reg, 1'b0};

    assign alpha_sum = {1'b0, prod} + afs_pkg::ALPHA_ROUND;
    assign alpha_raw = alpha_sum[52:32];
    assign alpha_val = (alpha_raw > 21'(afs_pkg::FADE_ONE)) ?
                       afs_pkg::FADE_ONE : alpha_raw[afs_pkg::FADE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        showing_next   = showing_reg;
        awaiting_next  = awaiting_reg;
        had_art_next   = had_art_reg;
        hold_left_next = hold_left_reg;
        fade_next      = fade_reg;
        move_next      = move_reg;
        up_next        = up_reg;
        rate_next      = rate_reg;
        dt_next        = dt_reg;
        summ_next      = summ_reg;
        dism_next      = dism_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_summ_next  = out_summ_reg;
        out_dism_next  = out_dism_reg;
        out_alpha_next = out_alpha_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            afs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == afs_pkg::ACT_HOLD)
                    begin
                        awaiting_next  = 1'b0;
                        had_art_next   = (in_hold != '0);
                        hold_left_next = in_hold;
                    end
                    else
                    begin
                        showing_next = show;
                        summ_next    = summ;
                        dism_next    = dism;
                        dt_next      = dt_clamped;
                        up_next      = show;
                        rate_next    = show ? pop_rate_reg :
                                       (had_art_eff ? exit_rate_reg : leave_rate_reg);
                        move_next    = 1'b0;
                        if (dism)
                        begin
                            awaiting_next = 1'b1;
                        end
                        else
                        begin
                            awaiting_next = 1'b0;
                            had_art_next  = had_art_eff;
                            hold_left_next = hold_base;
                            if (hold_base != '0)
                            begin
                                hold_left_next = (hold_base > afs_pkg::HOLD_W'(dt_clamped)) ?
                                                 hold_base - afs_pkg::HOLD_W'(dt_clamped) : '0;
                            end
                            else
                            begin
                                move_next = 1'b1;
                            end
                        end
                        state_next = (!dism && hold_base == '0) ?
                                     afs_pkg::ST_STEP : afs_pkg::ST_SQUARE;
                    end
                end
            end
            afs_pkg::ST_STEP:
            begin
                mul_en     = 1'b1;
                mul_a      = afs_pkg::MUL_A_W'(dt_reg);
                mul_b      = afs_pkg::MUL_B_W'(rate_reg);
                state_next = afs_pkg::ST_APPLY;
            end
            afs_pkg::ST_APPLY:
            begin
                if (move_reg && up_reg)
                begin
                    fade_next = (step >= afs_pkg::STEP_W'(room)) ?
                                afs_pkg::FADE_ONE : fade_reg + step[afs_pkg::FADE_W-1:0];
                end
                else if (move_reg)
                begin
                    fade_next = (step >= afs_pkg::STEP_W'(fade_reg)) ?
                                '0 : fade_reg - step[afs_pkg::FADE_W-1:0];
                end
                state_next = afs_pkg::ST_SQUARE;
            end
            afs_pkg::ST_SQUARE:
            begin
                mul_en     = 1'b1;
                mul_a      = afs_pkg::MUL_A_W'(fade_reg);
                mul_b      = afs_pkg::MUL_B_W'(fade_reg);
                state_next = afs_pkg::ST_CUBE;
            end
            afs_pkg::ST_CUBE:
            begin
                mul_en     = 1'b1;
                mul_a      = prod[afs_pkg::MUL_A_W-1:0];
                mul_b      = smooth_k;
                state_next = afs_pkg::ST_DONE;
            end
            afs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_summ_next  = summ_reg;
                    out_dism_next  = dism_reg;
                    out_alpha_next = alpha_val;
                    state_next     = afs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= afs_pkg::ST_IDLE;
            pop_rate_reg   <= afs_pkg::POP_RATE_RESET;
            leave_rate_reg <= afs_pkg::LEAVE_RATE_RESET;
            exit_rate_reg  <= afs_pkg::EXIT_RATE_RESET;
            showing_reg    <= 1'b0;
            awaiting_reg   <= 1'b0;
            had_art_reg    <= 1'b0;
            hold_left_reg  <= '0;
            fade_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            showing_reg   <= showing_next;
            awaiting_reg  <= awaiting_next;
            had_art_reg   <= had_art_next;
            hold_left_reg <= hold_left_next;
            fade_reg      <= fade_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (afs_pkg::reg_index_t'(cfg_index))
                    afs_pkg::REG_POP_RATE:   pop_rate_reg   <= cfg_data;
                    afs_pkg::REG_LEAVE_RATE: leave_rate_reg <= cfg_data;
                    afs_pkg::REG_EXIT_RATE:  exit_rate_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        move_reg      <= move_next;
        up_reg        <= up_next;
        rate_reg      <= rate_next;
        dt_reg        <= dt_next;
        summ_reg      <= summ_next;
        dism_reg      <= dism_next;
        out_summ_reg  <= out_summ_next;
        out_dism_reg  <= out_dism_next;
        out_alpha_reg <= out_alpha_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_alpha_reg, out_dism_reg, out_summ_reg};

    `AFS_NEVER(a_fade_in_range, clk, rst_n, fade_reg > afs_pkg::FADE_ONE)
    `AFS_ASSERT(a_alpha_in_range, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[18:2] <= afs_pkg::FADE_ONE))
    `AFS_ASSERT(a_result_from_done, clk, rst_n, $rose(m_axis_tvalid) |-> $past(state_reg == afs_pkg::ST_DONE))
    `AFS_ASSERT(a_arrival_clears_hold, clk, rst_n, (in_xfer && s_axis_tuser == afs_pkg::ACT_FRAME && summ) |=> (hold_left_reg == '0))

endmodule
`default_nettype wire

// ===== src/afs_mul_unit.sv =====
// Shared multiplier of the fade sequencer with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module afs_mul_unit (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [afs_pkg::MUL_A_W-1:0] a,
    input  wire logic [afs_pkg::MUL_B_W-1:0] b,
    output logic      [afs_pkg::PROD_W-1:0]  prod
);

    logic [afs_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= afs_pkg::PROD_W'(a) * afs_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== dv/tb_appearance_fade_sequencer.sv =====
// Self-checking testbench for the appearance fade sequencer: directed and randomized streams.
`timescale 1ns / 1ps
module tb_appearance_fade_sequencer;
    import afs_pkg::*;

    typedef struct packed {
        action_t     action;
        logic        wanted;
        logic        blocker;
        logic [15:0] elapsed;
        logic [19:0] hold_time;
    } fade_item_t;

    typedef struct packed {
        logic        summoned;
        logic        dismissed;
        logic [16:0] alpha;
    } fade_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_write_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [RATE_W-1:0]     cfg_data = '0;

    appearance_fade_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [15:0]  rate_cfg [0:2];
    logic         seen_showing;
    logic         exit_pending;
    logic         exit_played;
    logic [19:0]  hold_rem;
    logic [16:0]  fade_now;
    logic         dismissed_last;
    fade_result_t fade_results_due [$];

    int  mismatches = 0;
    int  frames_sent = 0;
    int  holds_sent = 0;
    int  cfg_writes = 0;
    int  settings_run = 0;
    int  results_checked = 0;
    int  summons_seen = 0;
    int  dismissals_seen = 0;

    bit  sender_gaps = 1'b1;
    bit  receiver_stalls = 1'b1;
    int  burst_left = 0;
    logic [31:0] ready_pattern = '1;
    int  ready_phase = 0;

    function automatic logic [16:0] opacity_of(input logic [16:0] f);
        logic [63:0] fl;
        logic [63:0] sq;
        logic [63:0] k;
        logic [63:0] a;
        fl = {47'd0, f};
        sq = fl * fl;
        k = 64'd196608 - 64'd2 * fl;
        a = (sq * k + 64'd2147483648) >> 32;
        return (a > 64'd65536) ? FADE_ONE : a[16:0];
    endfunction

    function automatic logic [31:0] ramp_amount(input logic [15:0] dt, input logic [15:0] rate);
        logic [63:0] p;
        p = {48'd0, dt} * {48'd0, rate} + 64'd128;
        return p[39:8];
    endfunction

    task automatic advance_fade_model(input fade_item_t it);
        logic [15:0]  dt;
        logic         show;
        logic [31:0]  s;
        fade_result_t r;
        if (it.action == ACT_HOLD)
        begin
            exit_pending = 1'b0;
            exit_played = (it.hold_time != 20'd0);
            hold_rem = it.hold_time;
            holds_sent++;
            return;
        end
        frames_sent++;
        dt = (it.elapsed > ELAPSED_CLAMP) ? ELAPSED_CLAMP : it.elapsed;
        show = it.wanted && !it.blocker;
        r = '0;
        if (show != seen_showing)
        begin
            seen_showing = show;
            r.summoned = show;
            r.dismissed = !show;
            exit_pending = !show;
            if (show)
                hold_rem = 20'd0;
        end
        if (!r.dismissed)
        begin
            if (exit_pending)
            begin
                exit_pending = 1'b0;
                exit_played = 1'b0;
            end
            if (hold_rem != 20'd0)
            begin
                hold_rem = (hold_rem > {4'd0, dt}) ? hold_rem - {4'd0, dt} : 20'd0;
            end
            else if (seen_showing)
            begin
                s = ramp_amount(dt, rate_cfg[REG_POP_RATE]);
                fade_now = (s >= 32'(FADE_ONE - fade_now)) ? FADE_ONE : fade_now + s[16:0];
            end
            else
            begin
                s = ramp_amount(dt, exit_played ? rate_cfg[REG_EXIT_RATE]
                                                : rate_cfg[REG_LEAVE_RATE]);
                fade_now = (s >= 32'(fade_now)) ? 17'd0 : fade_now - s[16:0];
            end
        end
        r.alpha = opacity_of(fade_now);
        dismissed_last = r.dismissed;
        fade_results_due.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        fade_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (fade_results_due.size() == 0)
            begin
                flag_mismatch("unexpected result alpha", int'(m_axis_tdata[18:2]), -1);
            end
            else
            begin
                want = fade_results_due.pop_front();
                results_checked++;
                if (want.summoned)
                    summons_seen++;
                if (want.dismissed)
                    dismissals_seen++;
                if (m_axis_tdata[0] !== want.summoned)
                    flag_mismatch("summoned", int'(m_axis_tdata[0]), int'(want.summoned));
                if (m_axis_tdata[1] !== want.dismissed)
                    flag_mismatch("dismissed", int'(m_axis_tdata[1]), int'(want.dismissed));
                if (m_axis_tdata[18:2] !== want.alpha)
                    flag_mismatch("alpha", int'(m_axis_tdata[18:2]), int'(want.alpha));
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_phase == 0)
        begin
            ready_pattern = $urandom;
            if ($urandom_range(0, 3) == 0)
                ready_pattern = '1;
            ready_pattern[$urandom_range(0, 31)] = 1'b1;
        end
        m_axis_tready <= !receiver_stalls || ready_pattern[ready_phase];
        ready_phase = (ready_phase + 1) % 32;
    end

    task automatic send_item(input fade_item_t it);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {2'b00, it.hold_time, it.elapsed, it.blocker, it.wanted};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_fade_model(it);
        if (sender_gaps)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap = $urandom_range(1, 10);
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                s_axis_tuser  <= 1'($urandom);
                s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_frame(input logic w, input logic b, input logic [15:0] dt);
        fade_item_t it;
        it.action = ACT_FRAME;
        it.wanted = w;
        it.blocker = b;
        it.elapsed = dt;
        it.hold_time = 20'($urandom);
        send_item(it);
    endtask

    task automatic send_hold(input logic [19:0] ht);
        fade_item_t it;
        it.action = ACT_HOLD;
        it.wanted = 1'($urandom);
        it.blocker = 1'($urandom);
        it.elapsed = 16'($urandom);
        it.hold_time = ht;
        send_item(it);
    endtask

    task automatic write_rate(input reg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx != REG_UNUSED)
            rate_cfg[int'(idx)] = val;
        cfg_writes++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (fade_results_due.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic test_default_ramp();
        settings_run++;
        send_frame(1'b0, 1'b0, 16'd0);
        send_frame(1'b1, 1'b0, 16'd0);
        send_frame(1'b1, 1'b0, 16'd1000);
        send_frame(1'b1, 1'b0, 16'd2000);
        send_frame(1'b1, 1'b0, 16'd16385);
        send_frame(1'b1, 1'b0, 16'hFFFF);
        send_frame(1'b1, 1'b0, 16'd16384);
    endtask

    task automatic test_show_and_hold();
        send_frame(1'b1, 1'b1, 16'd2000);
        send_hold(20'd5000);
        send_frame(1'b0, 1'b0, 16'd3000);
        send_frame(1'b0, 1'b0, 16'd3000);
        send_frame(1'b0, 1'b0, 16'd3000);
        send_frame(1'b1, 1'b0, 16'd4000);
        send_hold(20'hFFFFF);
        send_frame(1'b1, 1'b0, 16'hFFFF);
        send_frame(1'b0, 1'b0, 16'd1000);
        send_frame(1'b0, 1'b1, 16'd1000);
        send_frame(1'b1, 1'b0, 16'd1500);
        send_frame(1'b0, 1'b0, 16'd500);
        send_hold(20'd0);
        send_frame(1'b0, 1'b1, 16'd2500);
    endtask

    task automatic test_rate_extremes();
        settle();
        write_rate(REG_POP_RATE, 16'hFFFF);
        write_rate(REG_LEAVE_RATE, 16'd0);
        write_rate(REG_EXIT_RATE, 16'd0);
        write_rate(REG_UNUSED, 16'hFFFF);
        settings_run++;
        send_frame(1'b1, 1'b0, 16'd1);
        send_frame(1'b1, 1'b0, 16'd300);
        send_frame(1'b0, 1'b0, 16'd100);
        send_frame(1'b0, 1'b0, 16'hFFFF);
        settle();
        write_rate(REG_POP_RATE, 16'd0);
        write_rate(REG_LEAVE_RATE, 16'hFFFF);
        settings_run++;
        send_frame(1'b1, 1'b0, 16'hFFFF);
        send_frame(1'b0, 1'b0, 16'd1);
        send_frame(1'b0, 1'b0, 16'd1);
    endtask

    task automatic run_random_frames(input int frames);
        logic want;
        int   run_left;
        int   pick;
        int   hpick;
        logic [19:0] ht;
        want = 1'b0;
        run_left = 0;
        for (int n = 0; n < frames; n++)
        begin
            if (run_left == 0)
            begin
                want = ~want;
                run_left = $urandom_range(1, 24);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            send_frame(want ^ (pick >= 96), pick < 6,
                       (pick % 7 == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)));
            if ((dismissed_last && $urandom_range(0, 3) != 0) || pick == 50)
            begin
                hpick = $urandom_range(0, 7);
                if (hpick == 0)
                    ht = 20'd0;
                else if (hpick == 1)
                    ht = 20'($urandom);
                else
                    ht = 20'($urandom_range(1, 20000));
                send_hold(ht);
            end
        end
    endtask

    task automatic test_random_phases();
        int sel;
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_rate(REG_POP_RATE, 16'($urandom));
                    write_rate(REG_LEAVE_RATE, 16'($urandom));
                    write_rate(REG_EXIT_RATE, 16'($urandom));
                    write_rate(REG_UNUSED, 16'($urandom));
                end
                1:
                begin
                    write_rate(REG_POP_RATE, 16'hFFFF);
                    write_rate(REG_LEAVE_RATE, 16'hFFFF);
                    write_rate(REG_EXIT_RATE, 16'hFFFF);
                end
                2:
                begin
                    write_rate(REG_POP_RATE, 16'($urandom_range(0, 1023)));
                    write_rate(REG_LEAVE_RATE, 16'($urandom_range(0, 1023)));
                    write_rate(REG_EXIT_RATE, 16'($urandom_range(0, 1023)));
                end
                3:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sel = $urandom_range(0, 2);
                        write_rate(reg_index_t'(i), (sel == 0) ? 16'd0 :
                                   (sel == 1) ? 16'hFFFF : 16'($urandom));
                    end
                end
                default:
                begin
                    write_rate(REG_POP_RATE, POP_RATE_RESET);
                    write_rate(REG_LEAVE_RATE, LEAVE_RATE_RESET);
                    write_rate(REG_EXIT_RATE, EXIT_RATE_RESET);
                end
            endcase
            settings_run++;
            sender_gaps = (ph != 1);
            receiver_stalls = (ph != 1);
            run_random_frames(220);
        end
    endtask

    initial
    begin
        rate_cfg[0] = POP_RATE_RESET;
        rate_cfg[1] = LEAVE_RATE_RESET;
        rate_cfg[2] = EXIT_RATE_RESET;
        seen_showing = 1'b0;
        exit_pending = 1'b0;
        exit_played = 1'b0;
        hold_rem = 20'd0;
        fade_now = 17'd0;
        dismissed_last = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_ramp();
        test_show_and_hold();
        test_rate_extremes();
        test_random_phases();
        settle();
        $display("Sent %0d frames and %0d exit-hold items under %0d rate settings (%0d writes).",
                 frames_sent, holds_sent, settings_run, cfg_writes);
        $display("Checked %0d results, %0d summons and %0d dismissals among them.",
                 results_checked, summons_seen, dismissals_seen);
        if (mismatches == 0 && fade_results_due.size() == 0)
            $display("tb_appearance_fade_sequencer OK");
        else
            $display("tb_appearance_fade_sequencer NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", fade_results_due.size());
        $display("tb_appearance_fade_sequencer NOT OK");
        $finish;
    end

endmodule
